@@ src/eventual_safe_nodes_engine_top_defines.svh @@
// ----------------------------------------------------------------------------
// Eventual safe nodes engine assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef EVENTUAL_SAFE_NODES_ENGINE_TOP_DEFINES_SVH
`define EVENTUAL_SAFE_NODES_ENGINE_TOP_DEFINES_SVH

// Check an implication on every clock outside reset.
`define ESN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ESN_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/esn_pkg.sv @@
// ----------------------------------------------------------------------------
// Eventual safe nodes package
// Sizes, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package esn_pkg;

  localparam int unsigned MaxNodes   = 1024;
  localparam int unsigned MaxEdges   = 4096;
  localparam int unsigned NodeW      = 10;
  localparam int unsigned CountW     = 11;
  localparam int unsigned EdgeAddrW  = 12;
  localparam int unsigned EdgeCntW   = 13;
  localparam int unsigned DegW       = 13;
  localparam int unsigned EdgeW      = 2 * NodeW;

  typedef struct packed {
    logic             edge_valid;
    logic [NodeW-1:0] from_node;
    logic [NodeW-1:0] to_node;
    logic             last_edge;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  word_index;
    logic [63:0] safe_bits;
    logic        last_word;
    logic        input_dropped;
  } out_item_t;

  typedef enum logic [3:0] {
    StLoad,
    StClear,
    StCntRd,
    StCntDeg,
    StCntWr,
    StInitRd,
    StInitChk,
    StPopRd,
    StPopNode,
    StScanRd,
    StScanEdge,
    StScanWr,
    StOutRd,
    StOutAcc,
    StOutSend
  } state_e;

endpackage

@@ src/esn_ram.sv @@
// ----------------------------------------------------------------------------
// Eventual safe nodes RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module esn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/eventual_safe_nodes_engine_top.sv @@
// ----------------------------------------------------------------------------
// Eventual safe nodes engine
// Loads a directed graph edge by edge, then peels nodes of out-degree zero off
// the reversed graph and returns the safe set as 64-bit bitmap words.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_data_i  (node_count, 11b)
//  in      | in_valid_i/in_ready_o   | in_item_i   (in_item_t)
//  out     | out_valid_o/out_ready_i | out_item_o  (out_item_t)
//
// Cycles: one edge transaction per cycle while loading. The item with
// last_edge starts a job that clears the degree RAM, counts out-degrees over
// the stored edges, seeds the queue with nodes of out-degree zero, peels the
// queued nodes and then sends the safe set word by word.
// Reset: asynchronous, active low; edge count and drop flag clear, degree
// RAM is swept at the start of each job. Input stalls for the whole job;
// each output word holds until taken.

module eventual_safe_nodes_engine_top
  import esn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CountW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);

  state_e                state_q, state_d;
  logic [CountW-1:0]     node_count_q;
  logic [EdgeCntW-1:0]   idx_q, idx_d, idx_nxt;
  logic [EdgeCntW-1:0]   total_q, total_d;
  logic                  dropped_q, dropped_d;
  logic [CountW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [NodeW-1:0]      node_q, node_d;
  logic [63:0]           bits_q, bits_d;

  logic [CountW-1:0]     n_eff, n_m1;
  logic                  in_acc, edge_ok;

  // Memory ports
  logic                  edge_we;
  logic [EdgeAddrW-1:0]  edge_waddr, edge_raddr;
  logic [EdgeW-1:0]      edge_wdata, edge_rdata;
  logic                  deg_we;
  logic [NodeW-1:0]      deg_waddr, deg_raddr;
  logic [DegW-1:0]       deg_wdata, deg_rdata;
  logic                  q_we;
  logic [NodeW-1:0]      q_waddr, q_raddr;
  logic [NodeW-1:0]      q_wdata, q_rdata;

  logic [NodeW-1:0]      e_from, e_to;
  logic                  e_in_range;

  // Clamp the node count to 1..MaxNodes.
  always_comb begin
    n_eff = node_count_q;
    if (node_count_q == '0) begin
      n_eff = CountW'(1);
    end else if (node_count_q > CountW'(MaxNodes)) begin
      n_eff = CountW'(MaxNodes);
    end
  end
  assign n_m1 = n_eff - CountW'(1);

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountW'(1);
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  assign in_ready_o = (state_q == StLoad);
  assign in_acc     = in_valid_i && in_ready_o;
  assign edge_ok    = ({1'b0, in_item_i.from_node} < n_eff)
                   && ({1'b0, in_item_i.to_node} < n_eff)
                   && !total_q[EdgeCntW-1];

  assign e_from     = edge_rdata[EdgeW-1:NodeW];
  assign e_to       = edge_rdata[NodeW-1:0];
  assign e_in_range = ({1'b0, e_from} < n_eff) && ({1'b0, e_to} < n_eff);
  assign idx_nxt    = idx_q + EdgeCntW'(1);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    total_d    = total_q;
    dropped_d  = dropped_q;
    head_d     = head_q;
    tail_d     = tail_q;
    node_d     = node_q;
    bits_d     = bits_q;
    edge_we    = 1'b0;
    edge_waddr = total_q[EdgeAddrW-1:0];
    edge_wdata = {in_item_i.from_node, in_item_i.to_node};
    edge_raddr = idx_q[EdgeAddrW-1:0];
    deg_we     = 1'b0;
    deg_waddr  = e_from;
    deg_wdata  = '0;
    deg_raddr  = e_from;
    q_we       = 1'b0;
    q_waddr    = tail_q[NodeW-1:0];
    q_wdata    = e_from;
    q_raddr    = head_q[NodeW-1:0];

    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (in_item_i.edge_valid) begin
            if (edge_ok) begin
              edge_we = 1'b1;
              total_d = total_q + EdgeCntW'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end
          if (in_item_i.last_edge) begin
            idx_d   = '0;
            head_d  = '0;
            tail_d  = '0;
            state_d = StClear;
          end
        end
      end
      // Sweep the degree RAM over the nodes in use.
      StClear: begin
        deg_we    = 1'b1;
        deg_waddr = idx_q[NodeW-1:0];
        deg_wdata = '0;
        if (idx_nxt == EdgeCntW'(n_eff)) begin
          idx_d   = '0;
          state_d = (total_d == '0) ? StInitRd : StCntRd;
        end else begin
          idx_d = idx_nxt;
        end
      end
      StCntRd: begin
        state_d = StCntDeg;
      end
      StCntDeg: begin
        if (e_in_range) begin
          state_d = StCntWr;
        end else if (idx_nxt == total_q) begin
          idx_d   = '0;
          state_d = StInitRd;
        end else begin
          idx_d   = idx_nxt;
          state_d = StCntRd;
        end
      end
      StCntWr: begin
        deg_we    = 1'b1;
        deg_wdata = deg_rdata + DegW'(1);
        if (idx_nxt == total_q) begin
          idx_d   = '0;
          state_d = StInitRd;
        end else begin
          idx_d   = idx_nxt;
          state_d = StCntRd;
        end
      end
      // Seed the queue with nodes of out-degree zero.
      StInitRd: begin
        deg_raddr = idx_q[NodeW-1:0];
        state_d   = StInitChk;
      end
      StInitChk: begin
        if (deg_rdata == '0) begin
          q_we    = 1'b1;
          q_wdata = idx_q[NodeW-1:0];
          tail_d  = tail_q + CountW'(1);
        end
        if (idx_nxt == EdgeCntW'(n_eff)) begin
          idx_d   = '0;
          state_d = StPopRd;
        end else begin
          idx_d   = idx_nxt;
          state_d = StInitRd;
        end
      end
      StPopRd: begin
        if (head_q == tail_q) begin
          idx_d   = '0;
          state_d = StOutRd;
        end else begin
          head_d  = head_q + CountW'(1);
          state_d = StPopNode;
        end
      end
      StPopNode: begin
        node_d  = q_rdata;
        idx_d   = '0;
        state_d = (total_q == '0) ? StPopRd : StScanRd;
      end
      StScanRd: begin
        state_d = StScanEdge;
      end
      StScanEdge: begin
        if ((e_to == node_q) && ({1'b0, e_from} < n_eff)) begin
          state_d = StScanWr;
        end else if (idx_nxt == total_q) begin
          state_d = StPopRd;
        end else begin
          idx_d   = idx_nxt;
          state_d = StScanRd;
        end
      end
      // Drop the predecessor's degree; queue it when it reaches zero.
      StScanWr: begin
        if (deg_rdata != '0) begin
          deg_we    = 1'b1;
          deg_wdata = deg_rdata - DegW'(1);
          if (deg_rdata == DegW'(1)) begin
            q_we   = 1'b1;
            tail_d = tail_q + CountW'(1);
          end
        end
        if (idx_nxt == total_q) begin
          state_d = StPopRd;
        end else begin
          idx_d   = idx_nxt;
          state_d = StScanRd;
        end
      end
      // A node is safe when its degree ended at zero.
      StOutRd: begin
        deg_raddr = idx_q[NodeW-1:0];
        state_d   = StOutAcc;
      end
      StOutAcc: begin
        bits_d = {(idx_q < EdgeCntW'(n_eff)) && (deg_rdata == '0), bits_q[63:1]};
        if (idx_q[5:0] == 6'd63) begin
          state_d = StOutSend;
        end else begin
          idx_d   = idx_nxt;
          state_d = StOutRd;
        end
      end
      StOutSend: begin
        if (out_ready_i) begin
          if (idx_q[9:6] == n_m1[9:6]) begin
            total_d   = '0;
            dropped_d = 1'b0;
            state_d   = StLoad;
          end else begin
            idx_d   = idx_nxt;
            state_d = StOutRd;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      idx_q     <= '0;
      total_q   <= '0;
      dropped_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      total_q   <= total_d;
      dropped_q <= dropped_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    bits_q <= bits_d;
  end

  assign out_valid_o              = (state_q == StOutSend);
  assign out_item_o.word_index    = idx_q[9:6];
  assign out_item_o.safe_bits     = bits_q;
  assign out_item_o.last_word     = (idx_q[9:6] == n_m1[9:6]);
  assign out_item_o.input_dropped = dropped_q;

  esn_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  esn_ram #(.Width(DegW), .Depth(MaxNodes)) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  esn_ram #(.Width(NodeW), .Depth(MaxNodes)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

endmodule

@@ src/esn_checker.sv @@
// ----------------------------------------------------------------------------
// Eventual safe nodes port checker
// Watches the top-level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "eventual_safe_nodes_engine_top_defines.svh"

module esn_checker
  import esn_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // Hold a result until it is taken.
  `ESN_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // Never take edges while an answer is pending.
  `ESN_ASSERT_NEVER(a_no_overlap, in_ready_o && out_valid_o, "input open during output")

  // Return to loading right after the last word.
  `ESN_ASSERT(a_reload, out_valid_o && out_ready_i && out_item_o.last_word |=> in_ready_o,
    "no reload after last word")

  // After a word other than the last is taken, the input stays closed.
  `ESN_ASSERT(a_stall_after_start, out_valid_o && out_ready_i && !out_item_o.last_word |=>
    !in_ready_o, "input reopened mid answer")

endmodule

bind eventual_safe_nodes_engine_top esn_checker u_esn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eventual safe nodes engine testbench
// Streams directed edge lists into the engine under several handshake idling
// patterns and node-count settings, predicts the safe-node bitmap words with a
// behavioral peel of the reversed graph, and checks every output transaction.
// ----------------------------------------------------------------------------
module tb_top;
  import esn_pkg::*;

  localparam int unsigned WatchLimit = 300000;
  localparam int unsigned SettleCyc  = 60;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;

  eventual_safe_nodes_engine_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // Free-running clock, 8 ns period.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Stimulus and expectation stores.
  in_item_t  pending_edges[$];
  out_item_t expected_words[$];

  // Idling knobs, changed only while the block is idle.
  int unsigned in_idle_pct  = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_seq     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_cnt     = 0;

  int unsigned mismatches = 0;
  int unsigned items_queued = 0;

  // Predictor state: node count register and the stored edge list of the job.
  int unsigned    pred_nodes = 1;
  logic [NodeW-1:0] pred_from [MaxEdges];
  logic [NodeW-1:0] pred_to   [MaxEdges];
  int unsigned    pred_total = 0;
  bit             pred_dropped = 1'b0;

  // Accept one edge transaction into the predicted store and, on the job's
  // final item, peel the reversed graph and queue the bitmap words.
  task automatic predict_safe_words(input in_item_t it);
    int unsigned n, words, e, v, w, k, head, node;
    int unsigned deg [MaxNodes];
    bit          safe [MaxNodes];
    int unsigned ready_q [$];
    out_item_t   word;
    n = (pred_nodes == 0) ? 1 : ((pred_nodes > MaxNodes) ? MaxNodes : pred_nodes);
    if (it.edge_valid) begin
      if (it.from_node >= n || it.to_node >= n || pred_total >= MaxEdges) begin
        pred_dropped = 1'b1;
      end else begin
        pred_from[pred_total] = it.from_node;
        pred_to[pred_total]   = it.to_node;
        pred_total++;
      end
    end
    if (!it.last_edge) return;
    for (v = 0; v < MaxNodes; v++) begin
      deg[v]  = 0;
      safe[v] = 1'b0;
    end
    for (e = 0; e < pred_total; e++)
      if (pred_from[e] < n && pred_to[e] < n) deg[pred_from[e]]++;
    for (v = 0; v < n; v++)
      if (deg[v] == 0) ready_q.insert(ready_q.size(), v);
    head = 0;
    while (head < ready_q.size()) begin
      node = ready_q[head];
      head++;
      safe[node] = 1'b1;
      for (e = 0; e < pred_total; e++) begin
        if (pred_to[e] != node || pred_from[e] >= n || deg[pred_from[e]] == 0) continue;
        deg[pred_from[e]]--;
        if (deg[pred_from[e]] == 0) ready_q.insert(ready_q.size(), pred_from[e]);
      end
    end
    words = (n + 63) / 64;
    for (w = 0; w < words; w++) begin
      word.word_index    = w[3:0];
      word.safe_bits     = '0;
      for (k = 0; k < 64; k++)
        if (w * 64 + k < n && safe[w * 64 + k]) word.safe_bits[k] = 1'b1;
      word.last_word     = (w + 1 == words);
      word.input_dropped = pred_dropped;
      expected_words.insert(expected_words.size(), word);
    end
    pred_total   = 0;
    pred_dropped = 1'b0;
  endtask

  // Edge driver: hold each transaction until taken, advance from the queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_ready) predict_safe_words(in_item);
      if (!in_valid || in_ready) begin
        if (pending_edges.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_edges.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: drive backpressure, compare each word with the oldest
  // expectation. A long hold-off is counted here when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_word;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected word idx=%0d bits=%h last=%0b drop=%0b",
                     out_item.word_index, out_item.safe_bits, out_item.last_word,
                     out_item.input_dropped);
        end else begin
          exp_word = expected_words.pop_front();
          if (out_item !== exp_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: exp %0d %h %0b %0b / got %0d %h %0b %0b",
                       exp_word.word_index, exp_word.safe_bits, exp_word.last_word,
                       exp_word.input_dropped, out_item.word_index, out_item.safe_bits,
                       out_item.last_word, out_item.input_dropped);
          end
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_cnt  = 3000;
        out_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Watchdog: count cycles without any transaction.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write the node count register; only called while the block is idle.
  task automatic write_node_count(input int unsigned value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value[CountW-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    pred_nodes = value & 11'h7ff;
  endtask

  // Wait until every queued edge is taken and every word has arrived.
  task automatic drain_block();
    do @(posedge clk_i);
    while (pending_edges.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic push_edge(input bit vld, input int unsigned src, input int unsigned dst,
                           input bit last);
    in_item_t it;
    it.edge_valid = vld;
    it.from_node  = src[NodeW-1:0];
    it.to_node    = dst[NodeW-1:0];
    it.last_edge  = last;
    pending_edges.insert(pending_edges.size(), it);
    items_queued++;
  endtask

  // One random job: mostly in-range edges over n nodes, some noise.
  task automatic queue_random_job(input int unsigned n, input int unsigned edges);
    int unsigned i, lim;
    lim = (n == 0) ? 0 : ((n > MaxNodes) ? MaxNodes - 1 : n - 1);
    for (i = 0; i < edges; i++) begin
      case ($urandom_range(19))
        0:       push_edge(1'b0, $urandom, $urandom, 1'b0);
        1, 2:    push_edge(1'b1, $urandom_range(1023), $urandom_range(1023), 1'b0);
        default: push_edge(1'b1, $urandom_range(lim), $urandom_range(lim), 1'b0);
      endcase
    end
    if ($urandom_range(1)) push_edge(1'b0, $urandom, $urandom, 1'b1);
    else push_edge(1'b1, $urandom_range(lim), $urandom_range(lim), 1'b1);
  endtask

  initial begin
    int unsigned mode, n, i;
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero count treated as one node, bare end marker only.
    write_node_count(0);
    push_edge(1'b0, 0, 0, 1'b1);
    drain_block();
    // Oversized count clamps to the maximum; extreme node indices, self loop.
    write_node_count(2047);
    push_edge(1'b1, 1023, 0, 1'b0);
    push_edge(1'b1, 0, 1023, 1'b0);
    push_edge(1'b1, 5, 5, 1'b0);
    push_edge(1'b1, 682, 341, 1'b0);
    push_edge(1'b0, 1023, 1023, 1'b1);
    drain_block();
    // Out-of-range edges drop and flag; bare item without last does nothing.
    write_node_count(3);
    push_edge(1'b1, 3, 0, 1'b0);
    push_edge(1'b1, 0, 7, 1'b0);
    push_edge(1'b0, 2, 2, 1'b0);
    push_edge(1'b1, 0, 1, 1'b0);
    push_edge(1'b1, 1, 2, 1'b1);
    drain_block();
    // Count shrinks mid-job: stale edges ignored without a drop flag.
    write_node_count(10);
    push_edge(1'b1, 8, 9, 1'b0);
    push_edge(1'b1, 1, 2, 1'b0);
    push_edge(1'b1, 2, 1, 1'b0);
    drain_block();
    write_node_count(5);
    push_edge(1'b0, 0, 0, 1'b1);
    drain_block();
    // Word boundaries.
    write_node_count(64);
    push_edge(1'b1, 63, 62, 1'b1);
    drain_block();
    write_node_count(65);
    push_edge(1'b1, 64, 63, 1'b0);
    push_edge(1'b1, 63, 64, 1'b1);
    drain_block();
    write_node_count(1024);
    push_edge(1'b1, 1023, 1023, 1'b1);
    drain_block();
    items_queued = 0;

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (mode = 0; mode < 4; mode++) begin
      in_idle_pct   = (mode == 1) ? 80 : ((mode == 3) ? 23 : 0);
      out_stall_pct = (mode == 2) ? 80 : ((mode == 3) ? 23 : 0);
      if (mode == 2) begin
        // Long receiver hold-off while the sender keeps offering.
        write_node_count(1024);
        hold_seq++;
        queue_random_job(1024, 6);
        queue_random_job(40, 8);
        queue_random_job(40, 8);
        drain_block();
      end
      while (items_queued < (mode + 1) * 100) begin
        case ($urandom_range(9))
          0:       n = 1024 + $urandom_range(1023);
          1:       n = $urandom_range(1) ? 0 : 1;
          2:       n = $urandom_range(200, 1023);
          default: n = $urandom_range(2, 130);
        endcase
        write_node_count(n);
        for (i = $urandom_range(1, 3); i != 0; i--)
          queue_random_job(n, (n > 300) ? $urandom_range(0, 8) : $urandom_range(0, 14));
        drain_block();
      end
    end

    drain_block();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
